>>> sv/rmss_pkg.sv
// ----------------------------------------------------------------------------
// rmss_pkg
// Shared types and constants for the running median sorted store.
// ----------------------------------------------------------------------------
package rmss_pkg;

  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 9;

  // link between neighboring cells: whether the left cell keeps its value
  // on insert, and the value it hands to the right
  typedef struct packed {
    logic                       keep;
    logic signed [SAMPLE_W-1:0] value;
  } link_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

endpackage

>>> sv/rmss_cell.sv
// ----------------------------------------------------------------------------
// rmss_cell
// One rank of the sorted store. On insert it keeps its value, takes the new
// sample, or takes its left neighbor's value, and it offers its value as a
// leaf of the median readout when its rank is selected.
// ----------------------------------------------------------------------------
module rmss_cell #(
  parameter int IDX_W = 8,
  parameter int CNT_W = 9,
  parameter int IDX   = 0
) (
  input  logic                                clk_i,
  input  logic                                ins_i,
  input  logic signed [rmss_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [CNT_W-1:0]                    count_i,
  input  logic [IDX_W-1:0]                    lo_i,
  input  logic [IDX_W-1:0]                    hi_i,
  input  rmss_pkg::link_t                     prev_i,
  output rmss_pkg::link_t                     link_o,
  output logic [2*rmss_pkg::SAMPLE_W-1:0]     leaf_o
);
  import rmss_pkg::*;

  logic signed [SAMPLE_W-1:0] value_q, value_d;
  logic                       occupied;

  assign occupied = CNT_W'(IDX) < count_i;

  assign link_o.keep  = occupied && (value_q <= sample_i);
  assign link_o.value = value_q;

  always_comb begin
    value_d = value_q;
    if (ins_i && !link_o.keep) begin
      value_d = prev_i.keep ? sample_i : prev_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign leaf_o[SAMPLE_W-1:0]          = (IDX_W'(IDX) == lo_i) ? value_q : '0;
  assign leaf_o[2*SAMPLE_W-1:SAMPLE_W] = (IDX_W'(IDX) == hi_i) ? value_q : '0;

endmodule

>>> sv/rmss_or_tree.sv
// ----------------------------------------------------------------------------
// rmss_or_tree
// Registered binary OR tree. At most one leaf per bit lane is nonzero, so the
// root carries the selected leaf after the leaf registers and each inner level.
// ----------------------------------------------------------------------------
module rmss_or_tree #(
  parameter int W   = 64,
  parameter int LVL = 8
) (
  input  logic         clk_i,
  input  logic [W-1:0] leaf_i [1<<LVL],
  output logic [W-1:0] root_o
);
  import rmss_pkg::*;

  localparam int LEAVES = 1 << LVL;
  localparam int NODES  = 2 * LEAVES - 1;

  logic [W-1:0] node_q [NODES];

  for (genvar k = 0; k < NODES; k++) begin : g_node
    if (k >= LEAVES - 1) begin : g_leaf
      always_ff @(posedge clk_i) begin
        node_q[k] <= leaf_i[k-(LEAVES-1)];
      end
    end else begin : g_inner
      always_ff @(posedge clk_i) begin
        node_q[k] <= node_q[2*k+1] | node_q[2*k+2];
      end
    end
  end

  assign root_o = node_q[0];

endmodule

>>> sv/running_median_sorted_store.sv
// ----------------------------------------------------------------------------
// running_median_sorted_store
// Sorted insertion into a chain of cells, median read out through a
// registered OR tree.
// ----------------------------------------------------------------------------
// the result is loaded once the cells insert and the readout tree settles
// a new beat waits until the previous result is in the output register
// insertion itself happens in all cells in parallel
// reset clears the count and the handshake state; cell contents are not reset
// and only ranks below the count are ever read
module running_median_sorted_store #(
  parameter int CAPACITY = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [rmss_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rmss_pkg::SAMPLE_W-1:0] lower_middle_o,
  output logic signed [rmss_pkg::SAMPLE_W-1:0] upper_middle_o,
  output logic [rmss_pkg::COUNT_W-1:0]         stored_count_o,
  output logic                                 dropped_o
);
  import rmss_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEAVES = 1 << IDX_W;
  localparam int STG_W  = $clog2(IDX_W + 2);
  localparam logic [STG_W-1:0] STG_LAST = STG_W'(IDX_W + 1);

  state_e             state_q, state_d;
  logic [STG_W-1:0]   stage_q, stage_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic               full, accept, ins, load;
  logic               drop_q, drop_d;
  logic               out_valid_q, out_valid_d;
  logic [2*SAMPLE_W-1:0] root;
  logic [2*SAMPLE_W-1:0] result_q;
  logic               res_drop_q;
  logic [CNT_W-1:0]   res_count_q;
  logic [CNT_W+COUNT_W-1:0] count_ext;
  logic [CNT_W-1:0]   count_m1;

  link_t              link [CAPACITY];
  logic [2*SAMPLE_W-1:0] leaf [LEAVES];

  assign full   = count_q == CNT_W'(CAPACITY);
  assign accept = in_valid_i && in_ready_o;
  assign ins    = accept && !full;

  assign count_d  = ins ? count_q + CNT_W'(1) : count_q;
  assign count_m1 = count_d - CNT_W'(1);
  assign lo_d     = IDX_W'(count_m1 >> 1);
  assign hi_d     = IDX_W'(count_d >> 1);
  assign drop_d   = full;

  // ---- cell chain ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t prev;
    if (i == 0) begin : g_head
      assign prev = '{keep: 1'b1, value: '0};
    end else begin : g_body
      assign prev = link[i-1];
    end
    rmss_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i    (clk_i),
      .ins_i    (ins),
      .sample_i (sample_i),
      .count_i  (count_q),
      .lo_i     (lo_q),
      .hi_i     (hi_q),
      .prev_i   (prev),
      .link_o   (link[i]),
      .leaf_o   (leaf[i])
    );
  end

  for (genvar i = CAPACITY; i < LEAVES; i++) begin : g_pad
    assign leaf[i] = '0;
  end

  rmss_or_tree #(
    .W   (2 * SAMPLE_W),
    .LVL (IDX_W)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (leaf),
    .root_o (root)
  );

  // ---- control ----
  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    load        = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_BUSY;
          stage_d = '0;
        end
      end
      ST_BUSY: begin
        if (stage_q != STG_LAST) begin
          stage_d = stage_q + STG_W'(1);
        end else if (!out_valid_q || out_ready_i) begin
          // root is settled, hand the beat to the output register
          load        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      drop_q <= drop_d;
    end
    if (load) begin
      result_q    <= root;
      res_drop_q  <= drop_q;
      res_count_q <= count_q;
    end
  end

  assign in_ready_o     = state_q == ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign lower_middle_o = result_q[SAMPLE_W-1:0];
  assign upper_middle_o = result_q[2*SAMPLE_W-1:SAMPLE_W];
  assign count_ext      = {{COUNT_W{1'b0}}, res_count_q};
  assign stored_count_o = count_ext[COUNT_W-1:0];
  assign dropped_o      = res_drop_q;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !full) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not bump the count");

  a_load_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_BUSY && stage_q == STG_LAST))
    else $error("result loaded before readout settled");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_drop_q) |-> full)
    else $error("dropped beat while store not full");

endmodule
